### rtl/mctt_pkg.sv
// shared types and constants of the periodic timer table
package mctt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int IDX_W       = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam logic [6:0] BASE_INTERVAL = 7'd100;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    localparam logic [1:0] KIND_FIRE  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_SUM   = 2'd3;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_BAD_START
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] target;
        logic [15:0] tag;
        logic [31:0] period;
        logic [31:0] now;
    } cmd_t;

    typedef struct packed {
        logic [31:0] target;
        logic [15:0] tag;
        logic [31:0] period;
        logic [31:0] deadline;
    } slot_t;

endpackage

### rtl/mctt_front.sv
// input side: accepts requests, drops unknown operations, flags invalid starts
module mctt_front (
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [111:0]         s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    output logic                 push,
    output mctt_pkg::cmd_t       push_cmd,
    input  logic                 q_full
);
    import mctt_pkg::*;

    logic [1:0] func;

    assign func          = s_axis_tuser;
    assign s_axis_tready = !q_full;

    always_comb
    begin
        push_cmd.target = s_axis_tdata[31:0];
        push_cmd.tag    = s_axis_tdata[47:32];
        push_cmd.period = s_axis_tdata[79:48];
        push_cmd.now    = s_axis_tdata[111:80];
        push_cmd.op     = OP_TICK;
        push            = 1'b0;
        unique case (func)
            FUNC_TICK:
            begin
                push_cmd.op = OP_TICK;
                push        = s_axis_tvalid && !q_full;
            end
            FUNC_START:
            begin
                if (s_axis_tdata[31:0] == 32'd0 || s_axis_tdata[79:48] == 32'd0)
                    push_cmd.op = OP_BAD_START;
                else
                    push_cmd.op = OP_START;
                push = s_axis_tvalid && !q_full;
            end
            FUNC_STOP:
            begin
                push_cmd.op = OP_STOP;
                push        = s_axis_tvalid && !q_full;
            end
            default:
            begin
                // unknown operation is taken and produces nothing
                push = 1'b0;
            end
        endcase
    end

endmodule

### rtl/mctt_queue.sv
// two-entry command queue between front and back
module mctt_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mctt_pkg::cmd_t       push_cmd,
    output logic                 full,
    input  logic                 pop,
    output logic                 avail,
    output mctt_pkg::cmd_t       head
);
    import mctt_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

### rtl/mctt_back.sv
// back side: walks the timer slots for each command and drives the result register
module mctt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_avail,
    input  mctt_pkg::cmd_t       q_head,
    output logic                 q_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);
    import mctt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_TSUM,
        ST_SRCH,
        ST_SHIFT
    } state_t;

    slot_t              mem [TIMER_SLOTS];

    state_t             state_reg, state_next;
    cmd_t               cur_reg, cur_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic [6:0]         ival_reg, ival_next;

    logic               ov_reg, ov_next;
    logic [1:0]         okind_reg, okind_next;
    logic [31:0]        otgt_reg, otgt_next;
    logic [15:0]        otag_reg, otag_next;
    logic               ook_reg, ook_next;
    logic               ofull_reg, ofull_next;
    logic [6:0]         oival_reg, oival_next;
    logic               orun_reg, orun_next;
    logic               olast_reg, olast_next;

    logic               can_emit;
    logic [CNT_W-1:0]   idx_inc;
    logic [IDX_W-1:0]   rd_addr;
    slot_t              rd_slot;
    logic               we;
    logic [IDX_W-1:0]   wr_addr;
    slot_t              wr_slot;
    logic               hit;

    assign can_emit = !ov_reg || m_axis_tready;
    assign idx_inc  = idx_reg + 1'b1;
    // compaction reads the entry above the one being written
    assign rd_addr  = (state_reg == ST_SHIFT) ? idx_inc[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign rd_slot  = mem[rd_addr];
    assign hit      = (rd_slot.target == cur_reg.target) && (rd_slot.tag == cur_reg.tag);

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {6'd0, orun_reg, oival_reg, ofull_reg, ook_reg, otag_reg, otgt_reg};

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_slot;
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        ival_next  = ival_reg;
        q_pop      = 1'b0;
        we         = 1'b0;
        wr_addr    = idx_reg[IDX_W-1:0];
        wr_slot    = rd_slot;

        ov_next    = ov_reg && !m_axis_tready;
        okind_next = okind_reg;
        otgt_next  = otgt_reg;
        otag_next  = otag_reg;
        ook_next   = ook_reg;
        ofull_next = ofull_reg;
        oival_next = oival_reg;
        orun_next  = orun_reg;
        olast_next = olast_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_avail)
                begin
                    q_pop     = 1'b1;
                    cur_next  = q_head;
                    idx_next  = '0;
                    ival_next = BASE_INTERVAL;
                    if (q_head.op == OP_TICK)
                        state_next = ST_TICK;
                    else
                        state_next = ST_SRCH;
                end
            end
            ST_TICK:
            begin
                if (idx_reg == cnt_reg)
                    state_next = ST_TSUM;
                else if (rd_slot.deadline < cur_reg.now)
                begin
                    if (can_emit)
                    begin
                        we                = 1'b1;
                        wr_slot.deadline  = cur_reg.now + rd_slot.period;
                        if (rd_slot.period < {25'd0, ival_reg})
                            ival_next = rd_slot.period[6:0];
                        idx_next   = idx_inc;
                        ov_next    = 1'b1;
                        okind_next = KIND_FIRE;
                        otgt_next  = rd_slot.target;
                        otag_next  = rd_slot.tag;
                        ook_next   = 1'b0;
                        ofull_next = 1'b0;
                        oival_next = 7'd0;
                        // base source is cleared for the duration of a tick
                        orun_next  = 1'b0;
                        run_next   = 1'b0;
                        olast_next = 1'b0;
                    end
                end
                else
                begin
                    if (rd_slot.period < {25'd0, ival_reg})
                        ival_next = rd_slot.period[6:0];
                    idx_next = idx_inc;
                end
            end
            ST_TSUM:
            begin
                if (can_emit)
                begin
                    run_next   = (cnt_reg != '0);
                    ov_next    = 1'b1;
                    okind_next = KIND_SUM;
                    otgt_next  = 32'd0;
                    otag_next  = 16'd0;
                    ook_next   = 1'b0;
                    ofull_next = 1'b0;
                    oival_next = ival_reg;
                    orun_next  = (cnt_reg != '0);
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH:
            begin
                if (cur_reg.op == OP_BAD_START)
                begin
                    if (can_emit)
                    begin
                        ov_next    = 1'b1;
                        okind_next = KIND_START;
                        otgt_next  = 32'd0;
                        otag_next  = 16'd0;
                        ook_next   = 1'b0;
                        ofull_next = 1'b0;
                        oival_next = 7'd0;
                        orun_next  = run_reg;
                        olast_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg != cnt_reg && !hit)
                    idx_next = idx_inc;
                else if (cur_reg.op == OP_STOP)
                begin
                    if (idx_reg == cnt_reg)
                    begin
                        if (can_emit)
                        begin
                            ov_next    = 1'b1;
                            okind_next = KIND_STOP;
                            otgt_next  = 32'd0;
                            otag_next  = 16'd0;
                            ook_next   = 1'b0;
                            ofull_next = 1'b0;
                            oival_next = 7'd0;
                            orun_next  = run_reg;
                            olast_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                        state_next = ST_SHIFT;
                end
                else if (can_emit)
                begin
                    // start: re-arm a match, else append, else report full
                    ov_next    = 1'b1;
                    okind_next = KIND_START;
                    otgt_next  = 32'd0;
                    oival_next = 7'd0;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                    if (idx_reg != cnt_reg || cnt_reg != CNT_W'(TIMER_SLOTS))
                    begin
                        we = 1'b1;
                        // a re-armed timer keeps its stored period
                        if (idx_reg != cnt_reg)
                            wr_slot.deadline = cur_reg.now + cur_reg.period;
                        else
                        begin
                            wr_slot.target   = cur_reg.target;
                            wr_slot.tag      = cur_reg.tag;
                            wr_slot.period   = cur_reg.period;
                            wr_slot.deadline = cur_reg.now + cur_reg.period;
                            cnt_next         = cnt_reg + 1'b1;
                        end
                        run_next   = run_reg || (cur_reg.tag != 16'd0);
                        otag_next  = cur_reg.tag;
                        ook_next   = 1'b1;
                        ofull_next = 1'b0;
                        orun_next  = run_reg || (cur_reg.tag != 16'd0);
                    end
                    else
                    begin
                        otag_next  = 16'd0;
                        ook_next   = 1'b0;
                        ofull_next = 1'b1;
                        orun_next  = run_reg;
                    end
                end
            end
            ST_SHIFT:
            begin
                if (idx_inc < cnt_reg)
                begin
                    we       = 1'b1;
                    wr_slot  = rd_slot;
                    idx_next = idx_inc;
                end
                else if (can_emit)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    ov_next    = 1'b1;
                    okind_next = KIND_STOP;
                    otgt_next  = 32'd0;
                    otag_next  = 16'd0;
                    ook_next   = 1'b1;
                    ofull_next = 1'b0;
                    oival_next = 7'd0;
                    orun_next  = run_reg;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            run_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            run_reg   <= run_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        ival_reg  <= ival_next;
        okind_reg <= okind_next;
        otgt_reg  <= otgt_next;
        otag_reg  <= otag_next;
        ook_reg   <= ook_next;
        ofull_reg <= ofull_next;
        oival_reg <= oival_next;
        orun_reg  <= orun_next;
        olast_reg <= olast_next;
    end

endmodule

### rtl/multi_channel_periodic_timer_table.sv
// top level of the periodic timer table
//
// requests arrive on the s_axis channel: tuser carries the operation (tick,
// start, stop), tdata the target, tag, period and current time. results leave
// on m_axis, tuser carrying the result kind and tlast marking the final result
// of a request. a tick yields one fire result per expired timer, then a summary
// with the next interval, the least of the base interval and the slot periods;
// start and stop each yield one reply. requests pass a two-entry queue, so up
// to two are taken while the back end is busy. the back end walks the slot
// table one entry per cycle through the single slot read port, pausing when a
// result is due and the receiver stalls. a request is registered in the queue
// before the back end takes it, and every result leaves from a register.
// reset empties the table and the queue and clears the running flag; slot
// contents need no clearing. when the receiver stalls, the result register
// holds and the table walk pauses at the next result until it is taken.
module multi_channel_periodic_timer_table (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // target[31:0], timer_tag[47:32], period_ms[79:48], time_now[111:80]
    input  logic [111:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fire_target[31:0], reply_tag[47:32], ok[48], table_full[49],
    // next_interval[56:50], master_running[57], zero[63:58]
    output logic [63:0]  m_axis_tdata,
    // kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import mctt_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_pop;
    logic q_avail;
    cmd_t q_head;

    mctt_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_cmd      (push_cmd),
        .q_full        (q_full)
    );

    mctt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .head     (q_head)
    );

    mctt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_avail       (q_avail),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
